// File: rtl/core/sdd_pkg.sv
// Shared types, constants and font functions for the seconds-to-digit-dots core.
package sdd_pkg;

  localparam int unsigned NUM_DIGITS = 4;
  localparam int unsigned GLYPH_ROWS = 5;
  localparam int unsigned GLYPH_DOTS = 15;

  typedef logic [3:0] digit_t;
  typedef logic [NUM_DIGITS-1:0][3:0] digits_t;
  typedef logic [GLYPH_DOTS-1:0] glyph_t;
  typedef logic [3:0] dot_idx_t;
  typedef logic [1:0] digit_sel_t;

  typedef enum logic {
    BK_IDLE,
    BK_RUN
  } back_state_t;

  // floor(t / 60) == (t * 34953) >> 21 for every 16-bit t
  localparam logic [15:0] DIV60_MUL   = 16'd34953;
  localparam int unsigned DIV60_SHIFT = 21;
  // floor(v / 10) == (v * 205) >> 11 for v < 100
  localparam logic [7:0]  DIV10_MUL   = 8'd205;
  localparam int unsigned DIV10_SHIFT = 11;
  localparam logic [6:0]  MAX_FIELD   = 7'd99;
  localparam digit_sel_t  LAST_DIGIT  = 2'd3;
  localparam logic [2:0]  TOP_ROW     = 3'd1;
  localparam logic [3:0]  DIGIT_RIGHT = 4'd2;

  // Lit dots of a digit in emission order: bit k*5+r is font column k, row r.
  function automatic glyph_t glyph(input digit_t d);
    logic [2:0][4:0] cols;
    glyph_t          m;
    case (d)
      4'd0:    cols = {5'h1F, 5'h11, 5'h1F};
      4'd1:    cols = {5'h00, 5'h00, 5'h1F};
      4'd2:    cols = {5'h17, 5'h15, 5'h1D};
      4'd3:    cols = {5'h15, 5'h15, 5'h1F};
      4'd4:    cols = {5'h1C, 5'h04, 5'h1F};
      4'd5:    cols = {5'h1D, 5'h15, 5'h17};
      4'd6:    cols = {5'h1F, 5'h15, 5'h17};
      4'd7:    cols = {5'h10, 5'h10, 5'h1F};
      4'd8:    cols = {5'h1F, 5'h15, 5'h1F};
      4'd9:    cols = {5'h1D, 5'h15, 5'h1F};
      default: cols = '0;
    endcase
    for (int k = 0; k < 3; k++) begin
      for (int r = 0; r < GLYPH_ROWS; r++) begin
        m[k*GLYPH_ROWS+r] = cols[k][GLYPH_ROWS-1-r];
      end
    end
    return m;
  endfunction

  function automatic logic [1:0] dot_col(input dot_idx_t i);
    logic [1:0] k;
    if (i >= 4'd10) begin
      k = 2'd2;
    end else if (i >= 4'd5) begin
      k = 2'd1;
    end else begin
      k = 2'd0;
    end
    return k;
  endfunction

  function automatic logic [2:0] dot_row(input dot_idx_t i);
    logic [3:0] r;
    if (i >= 4'd10) begin
      r = i - 4'd10;
    end else if (i >= 4'd5) begin
      r = i - 4'd5;
    end else begin
      r = i;
    end
    return r[2:0];
  endfunction

endpackage

// File: rtl/core/sdd_front.sv
// Front end: accepts a seconds count and converts it to four clamped decimal digits.
module sdd_front (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_push,
  output logic             in_full,
  input  logic [15:0]      in_total_seconds,
  output logic             q_push,
  output sdd_pkg::digits_t q_data,
  input  logic             q_full
);

  logic        s1_v_r, s1_v_nxt;
  logic [15:0] total_r, total_nxt;
  logic [31:0] prod_r, prod_nxt;
  logic        s2_v_r, s2_v_nxt;
  logic [6:0]  min_r, min_nxt;
  logic [6:0]  sec_r, sec_nxt;

  logic        s1_take, s2_take, accept;
  logic [10:0] quo;
  logic [16:0] quo60;
  logic [15:0] rem;
  logic [14:0] min_mul, sec_mul;
  logic [3:0]  min_tens, sec_tens;
  logic [6:0]  min_tens10, sec_tens10;

  assign s2_take = !s2_v_r || !q_full;
  assign s1_take = !s1_v_r || s2_take;
  assign in_full = !s1_take;
  assign accept  = in_push && s1_take;

  always_comb begin
    s1_v_nxt  = s1_v_r;
    total_nxt = total_r;
    prod_nxt  = prod_r;
    if (s1_take) begin
      s1_v_nxt = accept;
    end
    if (accept) begin
      total_nxt = in_total_seconds;
      prod_nxt  = in_total_seconds * sdd_pkg::DIV60_MUL;
    end
  end

  always_comb begin
    quo   = prod_r[31:sdd_pkg::DIV60_SHIFT];
    quo60 = {quo, 6'b0} - {4'b0, quo, 2'b0};
    rem   = total_r - quo60[15:0];
  end

  always_comb begin
    s2_v_nxt = s2_v_r;
    min_nxt  = min_r;
    sec_nxt  = sec_r;
    if (s2_take) begin
      s2_v_nxt = s1_v_r;
      if (quo > 11'(sdd_pkg::MAX_FIELD)) begin
        min_nxt = sdd_pkg::MAX_FIELD;
        sec_nxt = sdd_pkg::MAX_FIELD;
      end else begin
        min_nxt = quo[6:0];
        sec_nxt = rem[6:0];
      end
    end
  end

  always_comb begin
    min_mul    = min_r * sdd_pkg::DIV10_MUL;
    sec_mul    = sec_r * sdd_pkg::DIV10_MUL;
    min_tens   = min_mul[14:sdd_pkg::DIV10_SHIFT];
    sec_tens   = sec_mul[14:sdd_pkg::DIV10_SHIFT];
    min_tens10 = {min_tens, 3'b0} - 7'd0 + {2'b0, min_tens, 1'b0};
    sec_tens10 = {sec_tens, 3'b0} - 7'd0 + {2'b0, sec_tens, 1'b0};
  end

  assign q_push    = s2_v_r;
  assign q_data[0] = min_tens;
  assign q_data[1] = 4'(min_r - min_tens10);
  assign q_data[2] = sec_tens;
  assign q_data[3] = 4'(sec_r - sec_tens10);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
    end else begin
      s1_v_r <= s1_v_nxt;
      s2_v_r <= s2_v_nxt;
    end
    total_r <= total_nxt;
    prod_r  <= prod_nxt;
    min_r   <= min_nxt;
    sec_r   <= sec_nxt;
  end

endmodule

// File: rtl/core/sdd_queue.sv
// Small flop-based queue of digit sets between front and back end.
module sdd_queue #(
  parameter int unsigned DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  sdd_pkg::digits_t push_data,
  output logic             full,
  input  logic             pop,
  output sdd_pkg::digits_t head,
  output logic             empty
);

  localparam int unsigned PW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);

  sdd_pkg::digits_t mem_r [DEPTH];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic          do_push, do_pop;

  assign full    = count_r == CW'(DEPTH);
  assign empty   = count_r == '0;
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign head    = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

// File: rtl/core/sdd_back.sv
// Back end: walks four digits' lit font dots, one per unstalled cycle, into an output register.
module sdd_back (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             q_empty,
  input  sdd_pkg::digits_t q_head,
  output logic             q_pop,
  output logic             out_empty,
  input  logic             out_pop,
  output logic [3:0]       out_dot_x,
  output logic [2:0]       out_dot_y,
  output logic             out_final_dot
);

  sdd_pkg::back_state_t st_r, st_nxt;
  sdd_pkg::digits_t     digits_r, digits_nxt;
  sdd_pkg::digit_sel_t  dig_r, dig_nxt;
  sdd_pkg::glyph_t      rem_r, rem_nxt;
  logic                 ov_r, ov_nxt;
  logic [3:0]           x_r, x_nxt;
  logic [2:0]           y_r, y_nxt;
  logic                 fin_r, fin_nxt;

  logic                 out_ready, emit;
  sdd_pkg::glyph_t      low_bit, rem_clr;
  sdd_pkg::dot_idx_t    idx;
  logic                 last_of_digit, last_of_item;

  assign out_ready = !ov_r || out_pop;

  always_comb begin
    low_bit = rem_r & (~rem_r + 1'b1);
    rem_clr = rem_r & ~low_bit;
    idx     = '0;
    for (int i = 0; i < sdd_pkg::GLYPH_DOTS; i++) begin
      if (low_bit[i]) begin
        idx = 4'(i);
      end
    end
    last_of_digit = rem_clr == '0;
    last_of_item  = last_of_digit && (dig_r == sdd_pkg::LAST_DIGIT);
  end

  // next state
  always_comb begin
    st_nxt = st_r;
    case (st_r)
      sdd_pkg::BK_IDLE: begin
        if (!q_empty) begin
          st_nxt = sdd_pkg::BK_RUN;
        end
      end
      sdd_pkg::BK_RUN: begin
        if (out_ready && last_of_item) begin
          st_nxt = sdd_pkg::BK_IDLE;
        end
      end
      default: st_nxt = sdd_pkg::BK_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    q_pop = 1'b0;
    emit  = 1'b0;
    case (st_r)
      sdd_pkg::BK_IDLE: q_pop = !q_empty;
      sdd_pkg::BK_RUN:  emit  = out_ready;
      default: begin
        q_pop = 1'b0;
        emit  = 1'b0;
      end
    endcase
  end

  always_comb begin
    digits_nxt = digits_r;
    dig_nxt    = dig_r;
    rem_nxt    = rem_r;
    ov_nxt     = ov_r;
    x_nxt      = x_r;
    y_nxt      = y_r;
    fin_nxt    = fin_r;
    if (q_pop) begin
      digits_nxt = q_head;
      dig_nxt    = '0;
      rem_nxt    = sdd_pkg::glyph(q_head[0]);
    end else if (emit) begin
      if (last_of_digit) begin
        dig_nxt = dig_r + 1'b1;
        rem_nxt = sdd_pkg::glyph(digits_r[dig_nxt]);
      end else begin
        rem_nxt = rem_clr;
      end
    end
    if (out_ready) begin
      ov_nxt = emit;
    end
    if (emit) begin
      x_nxt   = {dig_r, 2'b00} + sdd_pkg::DIGIT_RIGHT - {2'b00, sdd_pkg::dot_col(idx)};
      y_nxt   = sdd_pkg::TOP_ROW + sdd_pkg::dot_row(idx);
      fin_nxt = last_of_item;
    end
  end

  assign out_empty     = !ov_r;
  assign out_dot_x     = x_r;
  assign out_dot_y     = y_r;
  assign out_final_dot = fin_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= sdd_pkg::BK_IDLE;
      ov_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      ov_r <= ov_nxt;
    end
    digits_r <= digits_nxt;
    dig_r    <= dig_nxt;
    rem_r    <= rem_nxt;
    x_r      <= x_nxt;
    y_r      <= y_nxt;
    fin_r    <= fin_nxt;
  end

endmodule

// File: rtl/core/seconds_to_digit_dots_core.sv
// Top level of the seconds-to-digit-dots core: front end, digit queue, dot walker.
//
//  channel   ports                                   transaction
//  input     in_push/in_full, in_total_seconds       one seconds count
//  result    out_pop/out_empty, out_dot_x/_y/_final  one lit dot (20..51 per input)
//
// The back end emits one dot per cycle while out_pop frees its register; each input
// is first loaded from the queue. The front registers the product, then minutes
// and seconds. QUEUE_DEPTH (2 or more) digit sets wait between front and back end,
// so the front keeps accepting while dots are drawn. Synchronous reset empties all
// stages. A withheld pop stalls only the dot walker; the front fills the queue.
module seconds_to_digit_dots_core #(
  parameter int unsigned QUEUE_DEPTH = 2
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_push,
  output logic        in_full,
  input  logic [15:0] in_total_seconds,
  output logic        out_empty,
  input  logic        out_pop,
  output logic [3:0]  out_dot_x,
  output logic [2:0]  out_dot_y,
  output logic        out_final_dot
);

  logic             q_push, q_full, q_pop, q_empty;
  sdd_pkg::digits_t q_wdata, q_head;

  sdd_front u_front (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_push          (in_push),
    .in_full          (in_full),
    .in_total_seconds (in_total_seconds),
    .q_push           (q_push),
    .q_data           (q_wdata),
    .q_full           (q_full)
  );

  sdd_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_wdata),
    .full      (q_full),
    .pop       (q_pop),
    .head      (q_head),
    .empty     (q_empty)
  );

  sdd_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .q_empty       (q_empty),
    .q_head        (q_head),
    .q_pop         (q_pop),
    .out_empty     (out_empty),
    .out_pop       (out_pop),
    .out_dot_x     (out_dot_x),
    .out_dot_y     (out_dot_y),
    .out_final_dot (out_final_dot)
  );

endmodule

// File: rtl/core/sdd_checker.sv
// Port-level checks for the seconds-to-digit-dots core, bound to the top level.
module sdd_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       out_empty,
  input logic       out_pop,
  input logic [3:0] out_dot_x,
  input logic [2:0] out_dot_y,
  input logic       out_final_dot
);

  a_reset_empty: assert property (@(posedge clk) !rst_n |=> out_empty)
    else $error("result queue not empty after reset");

  a_dot_range: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty |-> (out_dot_x <= 4'd14 && out_dot_y >= 3'd1 && out_dot_y <= 3'd5))
    else $error("dot outside the drawing area");

  a_final_in_last_digit: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && out_final_dot) |-> out_dot_x >= 4'd12)
    else $error("final dot not in the seconds-ones digit");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && !out_pop) |=>
      (!out_empty && $stable(out_dot_x) && $stable(out_dot_y) && $stable(out_final_dot)))
    else $error("waiting dot changed before pop");

endmodule

bind seconds_to_digit_dots_core sdd_checker u_sdd_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .out_empty     (out_empty),
  .out_pop       (out_pop),
  .out_dot_x     (out_dot_x),
  .out_dot_y     (out_dot_y),
  .out_final_dot (out_final_dot)
);

// File: test/seconds_to_digit_dots_core_tb.sv
// Testbench for seconds_to_digit_dots_core: random push/pop pacing, per-dot scoreboard.
module seconds_to_digit_dots_core_tb;

  localparam int IDLE_LIMIT = 4000;
  localparam int DRAIN_CYCLES = 120;
  localparam int RANDOM_ITEMS = 330;

  typedef struct packed {
    logic [3:0] x;
    logic [2:0] y;
    logic       last;
  } dot_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_push = 1'b0;
  logic        in_full;
  logic [15:0] in_total_seconds = '0;
  logic        out_empty;
  logic        out_pop = 1'b0;
  logic [3:0]  out_dot_x;
  logic [2:0]  out_dot_y;
  logic        out_final_dot;

  logic [15:0] pending_times[$];
  dot_t        expected_dots[$];
  int          times_total = 0;
  int          times_taken = 0;
  int          dots_seen = 0;
  int          clamped_times = 0;
  int          errors = 0;
  int          push_wait = 0;
  int          pop_wait = 0;
  int          pop_next;
  bit          push_burst = 1'b0;
  bit          pop_burst = 1'b0;
  int          idle_cycles = 0;
  dot_t        head;

  seconds_to_digit_dots_core DUT (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_push          (in_push),
    .in_full          (in_full),
    .in_total_seconds (in_total_seconds),
    .out_empty        (out_empty),
    .out_pop          (out_pop),
    .out_dot_x        (out_dot_x),
    .out_dot_y        (out_dot_y),
    .out_final_dot    (out_final_dot)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Font column k of digit d; bit 4 is the top row.
  function automatic logic [4:0] font_col(input int d, input int k);
    logic [14:0] g;
    case (d)
      0: g = {5'h1F, 5'h11, 5'h1F};
      1: g = {5'h1F, 5'h00, 5'h00};
      2: g = {5'h1D, 5'h15, 5'h17};
      3: g = {5'h1F, 5'h15, 5'h15};
      4: g = {5'h1F, 5'h04, 5'h1C};
      5: g = {5'h17, 5'h15, 5'h1D};
      6: g = {5'h17, 5'h15, 5'h1F};
      7: g = {5'h1F, 5'h10, 5'h10};
      8: g = {5'h1F, 5'h15, 5'h1F};
      default: g = {5'h1F, 5'h15, 5'h1D};
    endcase
    return g[14-5*k -: 5];
  endfunction

  task automatic render_seconds(input logic [15:0] t);
    int   mins;
    int   secs;
    int   digs[4];
    logic [4:0] bits;
    dot_t d;
    mins = t / 60;
    secs = t % 60;
    if (mins > 99) begin
      mins = 99;
      secs = 99;
      clamped_times++;
    end
    digs[0] = mins / 10;
    digs[1] = mins % 10;
    digs[2] = secs / 10;
    digs[3] = secs % 10;
    for (int i = 0; i < 4; i++) begin
      for (int k = 0; k < 3; k++) begin
        bits = font_col(digs[i], k);
        for (int r = 0; r < 5; r++) begin
          if (bits[4-r]) begin
            d.x = 4'(4 * i + 2 - k);
            d.y = 3'(1 + r);
            d.last = 1'b0;
            expected_dots.push_back(d);
          end
        end
      end
    end
    expected_dots[expected_dots.size()-1].last = 1'b1;
  endtask

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("mismatch at dot %0d: %s got %0d expected %0d", dots_seen, what, got, want);
    errors++;
  endtask

  function automatic int draw_gap(input bit no_idle);
    int p;
    p = $urandom_range(0, 99);
    if (no_idle || p < 55) begin
      return 0;
    end else if (p < 90) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(8, 40);
  endfunction

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_push <= 1'b0;
    end else begin
      if (in_push && !in_full) begin
        render_seconds(in_total_seconds);
        times_taken++;
      end
      if (!in_push || !in_full) begin
        if (push_wait > 0) begin
          in_push <= 1'b0;
          push_wait <= push_wait - 1;
        end else if (pending_times.size() > 0) begin
          in_push <= 1'b1;
          in_total_seconds <= pending_times.pop_front();
          push_wait <= draw_gap(push_burst);
          if ($urandom_range(0, 39) == 0) begin
            push_burst <= !push_burst;
          end
        end else begin
          in_push <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    if (!rst_n) begin
      out_pop <= 1'b0;
    end else begin
      pop_next = pop_wait;
      if (out_pop && !out_empty) begin
        if (expected_dots.size() == 0) begin
          // no dot expected: -1 stands for none
          report_mismatch("unexpected dot_x", out_dot_x, -1);
        end else begin
          head = expected_dots.pop_front();
          if (out_dot_x !== head.x) report_mismatch("dot_x", out_dot_x, head.x);
          if (out_dot_y !== head.y) report_mismatch("dot_y", out_dot_y, head.y);
          if (out_final_dot !== head.last) report_mismatch("final_dot", out_final_dot, head.last);
        end
        dots_seen++;
        pop_next = draw_gap(pop_burst);
        if ($urandom_range(0, 149) == 0) begin
          pop_burst <= !pop_burst;
        end
      end
      if (pop_next > 0) begin
        out_pop <= 1'b0;
        pop_wait <= pop_next - 1;
      end else begin
        out_pop <= 1'b1;
        pop_wait <= 0;
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_push && !in_full) || (out_pop && !out_empty)) begin
        idle_cycles <= 0;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("timeout: %0d of %0d inputs taken, %0d dots pending",
                 times_taken, times_total, expected_dots.size());
        $display("FAIL");
        $finish;
      end
    end
  end

  initial begin
    int p;
    // clamp edges, all digit values per position, all-ones / single-bit inputs
    pending_times = '{16'd0, 16'd59, 16'd60, 16'd599, 16'd600, 16'd5999, 16'd6000,
                      16'd6001, 16'd6059, 16'd6060, 16'd65535, 16'd32768, 16'd1,
                      16'd671, 16'd1342, 16'd2013, 16'd2684, 16'd3355, 16'd3966,
                      16'd4627, 16'd5288, 16'd5949, 16'd21845, 16'd43690};
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      p = $urandom_range(0, 99);
      if (p < 60) begin
        pending_times.push_back(16'($urandom_range(0, 5999)));
      end else if (p < 85) begin
        pending_times.push_back(16'($urandom_range(0, 65535)));
      end else begin
        pending_times.push_back(16'($urandom_range(5940, 6120)));
      end
    end
    times_total = pending_times.size();
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    wait (times_taken == times_total && expected_dots.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("rendered %0d time values (%0d clamped to 99:99), %0d dots checked",
             times_taken, clamped_times, dots_seen);
    if (errors == 0 && expected_dots.size() == 0) begin
      $display("PASS");
    end else begin
      $display("%0d mismatches", errors);
      $display("FAIL");
    end
    $finish;
  end

endmodule
